### design/cfte_pkg.sv
// shared constants, types and the arctangent table for the cube-face to panorama address block
// no dependencies
package cfte_pkg;

   localparam int MAX_FACE          = 2048;
   localparam int MAX_PANO_WIDTH    = 8192;
   localparam int COEF_BITS         = 16;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int P_FRAC            = 14;
   localparam int RAY_FRAC          = 28;
   localparam int ATAN_ENTRIES      = 24;

   localparam int FACE_W      = 12;
   localparam int PANO_W_BITS = 14;
   localparam int PANO_H_BITS = 13;
   localparam int ROT_BITS    = 48;
   localparam int IN_W        = 11;
   localparam int COL_W       = 13;
   localparam int ROWO_W      = 12;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_IDX_W   = 3;

   localparam int FW        = $clog2(MAX_FACE) + 1;
   localparam int QB        = P_FRAC + 1;
   localparam int PW        = P_FRAC + 2;
   localparam int PRW       = COEF_BITS + PW;
   localparam int SW        = PRW + 2;
   localparam int DOT_SHIFT = COEF_BITS - 2 + P_FRAC - RAY_FRAC;
   localparam int CW        = 36;
   localparam int AW        = 34;
   localparam int MAG_W     = 33;
   localparam int AU        = 33;

   localparam logic [29:0]          INV_GAIN  = 30'd652032874;
   localparam logic signed [AW-1:0] QUARTER   = AW'(64'sd1073741824);
   localparam longint               HALF_TURN = 64'sd2147483648;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FACE_SIZE,
      CSR_PANO_WIDTH,
      CSR_PANO_HEIGHT,
      CSR_ROT_A,
      CSR_ROT_B,
      CSR_ROT_C
   } csr_index_type;

   typedef struct packed {
      logic [FW-1:0] rem;
      logic [QB-1:0] q;
      logic          low;
      logic          neg;
   } div_lane_type;

   typedef struct packed {
      div_lane_type x_lane;
      div_lane_type z_lane;
   } div_word_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] ang;
      logic                 zero;
      logic signed [CW-1:0] side;
   } cordic_word_type;

   // arctangent of 2^-i in units of 2^32 per turn
   function automatic logic signed [AW-1:0] atan_of(input int i);
      logic [29:0] t;
      case (i)
         0:  t = 30'd536870912;
         1:  t = 30'd316933406;
         2:  t = 30'd167458907;
         3:  t = 30'd85004756;
         4:  t = 30'd42667331;
         5:  t = 30'd21354465;
         6:  t = 30'd10680862;
         7:  t = 30'd5340245;
         8:  t = 30'd2670163;
         9:  t = 30'd1335087;
         10: t = 30'd667544;
         11: t = 30'd333772;
         12: t = 30'd166886;
         13: t = 30'd83443;
         14: t = 30'd41722;
         15: t = 30'd20861;
         16: t = 30'd10430;
         17: t = 30'd5215;
         18: t = 30'd2608;
         19: t = 30'd1304;
         20: t = 30'd652;
         21: t = 30'd326;
         22: t = 30'd163;
         23: t = 30'd81;
         default: t = '0;
      endcase
      return $signed({{(AW-30){1'b0}}, t});
   endfunction

endpackage

### design/cfte_div_cell.sv
// one restoring division step for both ray lanes (px and pz)
// depends on cfte_pkg
module cfte_div_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic [cfte_pkg::FW-1:0]   n_eff,
   input  logic                      in_valid,
   input  cfte_pkg::div_word_type    in_word,
   output logic                      out_valid,
   output cfte_pkg::div_word_type    out_word
);
   import cfte_pkg::*;

   logic         valid_ff;
   div_word_type word_ff;
   div_word_type word_in;

   function automatic div_lane_type step(input div_lane_type l, input logic [FW-1:0] n);
      div_lane_type r;
      logic [FW:0]  t;
      logic [FW:0]  d;
      t = {l.rem, l.low};
      d = t - {1'b0, n};
      r = l;
      // dividend holds a single nonzero low bit, used once
      r.low = 1'b0;
      if (t >= {1'b0, n}) begin
         r.rem = d[FW-1:0];
         r.q   = {l.q[QB-2:0], 1'b1};
      end else begin
         r.rem = t[FW-1:0];
         r.q   = {l.q[QB-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      word_in.x_lane = step(in_word.x_lane, n_eff);
      word_in.z_lane = step(in_word.z_lane, n_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

### design/cfte_cordic_cell.sv
// one vectoring cordic rotation with fixed shift IDX
// depends on cfte_pkg
module cfte_cordic_cell #(
   parameter int IDX = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  cfte_pkg::cordic_word_type  in_word,
   output logic                       out_valid,
   output cfte_pkg::cordic_word_type  out_word
);
   import cfte_pkg::*;

   logic            valid_ff;
   cordic_word_type word_ff;
   cordic_word_type word_in;
   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;
   logic signed [CW-1:0] dx;
   logic signed [CW-1:0] dy;

   always_comb begin
      xs = in_word.x;
      ys = in_word.y;
      dx = ys >>> IDX;
      dy = xs >>> IDX;
      word_in = in_word;
      if (ys > 0) begin
         word_in.x   = xs + dx;
         word_in.y   = ys - dy;
         word_in.ang = in_word.ang + atan_of(IDX);
      end else begin
         word_in.x   = xs - dx;
         word_in.y   = ys + dy;
         word_in.ang = in_word.ang - atan_of(IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

### design/cubemap_face_to_equirect_address.sv
// channel  | direction | handshake            | word
// req      | in        | req_tvalid/tready    | face_col, face_row
// rsp      | out       | rsp_tvalid/tready    | src_col, src_row
// csr      | in        | csr_we               | csr_index, csr_wdata
// one word accepted per cycle while the output queue has room; results pass through
// the 15 divider cells and the two cordic cell chains
// the pipeline moves as a whole while the two-entry output queue has room
// reset is synchronous and empties the pipeline and the queue
// top level: cube-face pixel to panorama source address; uses cfte_pkg and the cells
module cubemap_face_to_equirect_address #(
   parameter int CORDIC_STAGES = cfte_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cfte_pkg::REQ_TDATA_W-1:0]    req_tdata,  // face_col, face_row, pad
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cfte_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // src_col, src_row, pad
   input  logic                                csr_we,
   input  logic [cfte_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cfte_pkg::ROT_BITS-1:0]       csr_wdata
);
   import cfte_pkg::*;

   localparam int CS = CORDIC_STAGES;

   // configuration
   logic [FACE_W-1:0]      face_size_ff;
   logic [PANO_W_BITS-1:0] pano_width_ff;
   logic [PANO_H_BITS-1:0] pano_height_ff;
   logic [ROT_BITS-1:0]    rot_a_ff, rot_b_ff, rot_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff   <= FACE_W'(512);
         pano_width_ff  <= PANO_W_BITS'(2048);
         pano_height_ff <= PANO_H_BITS'(1024);
         rot_a_ff       <= '0;
         rot_b_ff       <= '0;
         rot_c_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FACE_SIZE:   face_size_ff   <= csr_wdata[FACE_W-1:0];
            CSR_PANO_WIDTH:  pano_width_ff  <= csr_wdata[PANO_W_BITS-1:0];
            CSR_PANO_HEIGHT: pano_height_ff <= csr_wdata[PANO_H_BITS-1:0];
            CSR_ROT_A:       rot_a_ff       <= csr_wdata;
            CSR_ROT_B:       rot_b_ff       <= csr_wdata;
            CSR_ROT_C:       rot_c_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [FW-1:0]          n_eff;
   logic [PANO_W_BITS-1:0] w_eff;
   logic [PANO_H_BITS-1:0] h_eff;

   always_comb begin
      if (face_size_ff == '0) begin
         n_eff = FW'(1);
      end else if (FW'(face_size_ff) > FW'(MAX_FACE)) begin
         n_eff = FW'(MAX_FACE);
      end else begin
         n_eff = FW'(face_size_ff);
      end
      if (pano_width_ff == '0) begin
         w_eff = PANO_W_BITS'(1);
      end else if (pano_width_ff > PANO_W_BITS'(MAX_PANO_WIDTH)) begin
         w_eff = PANO_W_BITS'(MAX_PANO_WIDTH);
      end else begin
         w_eff = pano_width_ff;
      end
      if (pano_height_ff == '0) begin
         h_eff = PANO_H_BITS'(1);
      end else if (pano_height_ff > PANO_H_BITS'(MAX_PANO_WIDTH / 2)) begin
         h_eff = PANO_H_BITS'(MAX_PANO_WIDTH / 2);
      end else begin
         h_eff = pano_height_ff;
      end
   end

   // output queue and global advance
   logic [RSP_TDATA_W-1:0] slot0_ff, slot1_ff;
   logic [1:0]             cnt_ff;
   logic                   en;

   assign en         = (cnt_ff != 2'd2);
   assign req_tready = en;

   // front: clamp pixel, form signed numerators
   localparam int NW = FW + 3;
   logic [IN_W-1:0]        u_cl, v_cl;
   logic [FW-1:0]          nm1;
   logic signed [NW-1:0]   num_x, num_z, mag_x, mag_z;
   logic                   front_v_ff;
   div_word_type           front_w_ff, front_w_in;

   always_comb begin
      nm1   = n_eff - FW'(1);
      u_cl  = (FW'(req_tdata[IN_W-1:0]) > nm1) ? nm1[IN_W-1:0] : req_tdata[IN_W-1:0];
      v_cl  = (FW'(req_tdata[2*IN_W-1:IN_W]) > nm1) ? nm1[IN_W-1:0]
                                                     : req_tdata[2*IN_W-1:IN_W];
      num_x = $signed(NW'(n_eff) - NW'(2) - (NW'(u_cl) << 1));
      num_z = $signed((NW'(v_cl) << 1) - NW'(n_eff));
      mag_x = num_x[NW-1] ? -num_x : num_x;
      mag_z = num_z[NW-1] ? -num_z : num_z;
      // dividend is mag * 2^P_FRAC; quotient fits QB bits so start from mag >> 1
      front_w_in.x_lane.rem = FW'(mag_x[FW-1:1]);
      front_w_in.x_lane.low = mag_x[0];
      front_w_in.x_lane.q   = '0;
      front_w_in.x_lane.neg = num_x[NW-1];
      front_w_in.z_lane.rem = FW'(mag_z[FW-1:1]);
      front_w_in.z_lane.low = mag_z[0];
      front_w_in.z_lane.q   = '0;
      front_w_in.z_lane.neg = num_z[NW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else if (en) begin
         front_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_w_ff <= front_w_in;
      end
   end

   // divider chain
   logic [QB:0]  div_v;
   div_word_type div_w [QB+1];

   assign div_v[0] = front_v_ff;
   assign div_w[0] = front_w_ff;

   for (genvar k = 0; k < QB; k++) begin : g_div
      cfte_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .n_eff     (n_eff),
         .in_valid  (div_v[k]),
         .in_word   (div_w[k]),
         .out_valid (div_v[k+1]),
         .out_word  (div_w[k+1])
      );
   end

   // floor correction for negative numerators
   function automatic logic signed [PW-1:0] fix_lane(input div_lane_type l);
      logic [PW-1:0] q;
      q = PW'(l.q) + PW'(l.rem != '0);
      return l.neg ? $signed(-q) : $signed(PW'(l.q));
   endfunction

   logic                  fix_v_ff;
   logic signed [PW-1:0]  px_ff, pz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_v_ff <= 1'b0;
      end else if (en) begin
         fix_v_ff <= div_v[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= fix_lane(div_w[QB].x_lane);
         pz_ff <= fix_lane(div_w[QB].z_lane);
      end
   end

   // matrix products
   function automatic logic signed [COEF_BITS-1:0] coef(input logic [ROT_BITS-1:0] r,
                                                        input int j);
      return $signed(r[j*COEF_BITS +: COEF_BITS]);
   endfunction

   logic                   mul_v_ff;
   logic signed [PRW-1:0]  p0_ff [3];
   logic signed [PRW-1:0]  p2_ff [3];
   logic [ROT_BITS-1:0]    rows [3];

   assign rows[0] = rot_a_ff;
   assign rows[1] = rot_b_ff;
   assign rows[2] = rot_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
      end else if (en) begin
         mul_v_ff <= fix_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            p0_ff[r] <= coef(rows[r], 0) * px_ff;
            p2_ff[r] <= coef(rows[r], 2) * pz_ff;
         end
      end
   end

   // ray sums
   logic                  sum_v_ff;
   logic signed [CW-1:0]  ray_ff [3];
   logic signed [CW-1:0]  ray_in [3];
   logic signed [SW-1:0]  a0, a1, a2, acc;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         a0 = SW'(p0_ff[r]);
         a2 = SW'(p2_ff[r]);
         a1 = SW'(coef(rows[r], 1));
         acc = a0 + a2 + (a1 <<< P_FRAC);
         ray_in[r] = CW'(acc >>> DOT_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_v_ff <= 1'b0;
      end else if (en) begin
         sum_v_ff <= mul_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ray_ff <= ray_in;
      end
   end

   // left half-plane folds onto the right by a quarter turn
   function automatic cordic_word_type prerot(input logic signed [CW-1:0] x,
                                              input logic signed [CW-1:0] y,
                                              input logic signed [CW-1:0] side);
      cordic_word_type r;
      r.x    = x;
      r.y    = y;
      r.ang  = '0;
      r.side = side;
      r.zero = (x == '0) && (y == '0);
      if (x < 0) begin
         if (y >= 0) begin
            r.x   = y;
            r.y   = -x;
            r.ang = QUARTER;
         end else begin
            r.x   = -y;
            r.y   = x;
            r.ang = -QUARTER;
         end
      end
      return r;
   endfunction

   // longitude chain, side carries rz
   logic            pre1_v_ff;
   cordic_word_type pre1_w_ff;
   logic [CS:0]     c1_v;
   cordic_word_type c1_w [CS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         pre1_v_ff <= 1'b0;
      end else if (en) begin
         pre1_v_ff <= sum_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre1_w_ff <= prerot(ray_ff[0], ray_ff[1], ray_ff[2]);
      end
   end

   assign c1_v[0] = pre1_v_ff;
   assign c1_w[0] = pre1_w_ff;

   for (genvar k = 0; k < CS; k++) begin : g_lon
      cfte_cordic_cell #(.IDX(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (c1_v[k]),
         .in_word   (c1_w[k]),
         .out_valid (c1_v[k+1]),
         .out_word  (c1_w[k+1])
      );
   end

   // hypot by gain correction
   logic                      gain_v_ff;
   logic signed [CW-1:0]      h_ff, rz_ff;
   logic signed [AW-1:0]      lon_ff;
   logic [MAG_W-1:0]          mag;
   logic [MAG_W+29:0]         gprod;

   always_comb begin
      mag   = c1_w[CS].x[MAG_W-1:0];
      gprod = mag * INV_GAIN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_v_ff <= 1'b0;
      end else if (en) begin
         gain_v_ff <= c1_v[CS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_ff   <= $signed(CW'(gprod[MAG_W+29:30]));
         rz_ff  <= c1_w[CS].side;
         lon_ff <= c1_w[CS].zero ? '0 : c1_w[CS].ang;
      end
   end

   // latitude chain, side carries longitude
   logic            pre2_v_ff;
   cordic_word_type pre2_w_ff;
   logic [CS:0]     c2_v;
   cordic_word_type c2_w [CS+1];
   logic signed [CW-1:0] lon_ext;

   assign lon_ext = CW'(lon_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pre2_v_ff <= 1'b0;
      end else if (en) begin
         pre2_v_ff <= gain_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre2_w_ff <= prerot(h_ff, rz_ff, lon_ext);
      end
   end

   assign c2_v[0] = pre2_v_ff;
   assign c2_w[0] = pre2_w_ff;

   for (genvar k = 0; k < CS; k++) begin : g_lat
      cfte_cordic_cell #(.IDX(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (c2_v[k]),
         .in_word   (c2_w[k]),
         .out_valid (c2_v[k+1]),
         .out_word  (c2_w[k+1])
      );
   end

   // scale angles to panorama size
   logic                           scale_v_ff;
   logic [PANO_W_BITS+AU-1:0]      pc_ff;
   logic [PANO_H_BITS+AU-1:0]      pr_ff;
   logic signed [AW:0]             lon_x, lat_x, a_s, b_s;
   logic [AU-1:0]                  a_u, b_u;

   always_comb begin
      lon_x = (AW+1)'($signed(c2_w[CS].side[AW-1:0]));
      lat_x = c2_w[CS].zero ? '0 : (AW+1)'(c2_w[CS].ang);
      a_s   = lon_x + (AW+1)'(HALF_TURN);
      b_s   = lat_x + (AW+1)'(HALF_TURN / 2);
      a_u   = a_s[AW] ? '0 : a_s[AU-1:0];
      b_u   = b_s[AW] ? '0 : b_s[AU-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_v_ff <= 1'b0;
      end else if (en) begin
         scale_v_ff <= c2_v[CS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pc_ff <= w_eff * a_u;
         pr_ff <= h_eff * b_u;
      end
   end

   // saturate at the seam and pack the result word
   localparam int CFW = PANO_W_BITS + AU - 32;
   localparam int RFW = PANO_H_BITS + AU - 31;
   logic [CFW-1:0]          col_full, w_m1;
   logic [RFW-1:0]          row_full, h_m1;
   logic [COL_W-1:0]        src_col;
   logic [ROWO_W-1:0]       src_row;
   logic [RSP_TDATA_W-1:0]  out_word;

   always_comb begin
      col_full = pc_ff[PANO_W_BITS+AU-1:32];
      row_full = pr_ff[PANO_H_BITS+AU-1:31];
      w_m1     = CFW'(w_eff - PANO_W_BITS'(1));
      h_m1     = RFW'(h_eff - PANO_H_BITS'(1));
      src_col  = (col_full > w_m1) ? w_m1[COL_W-1:0] : col_full[COL_W-1:0];
      src_row  = (row_full > h_m1) ? h_m1[ROWO_W-1:0] : row_full[ROWO_W-1:0];
      out_word = {{(RSP_TDATA_W-COL_W-ROWO_W){1'b0}}, src_row, src_col};
   end

   logic push, pop;

   assign push       = en && scale_v_ff;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = slot0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         priority if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end else begin
            cnt_ff <= cnt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (push && pop) begin
         slot0_ff <= (cnt_ff == 2'd1) ? out_word : slot1_ff;
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            slot0_ff <= out_word;
         end else begin
            slot1_ff <= out_word;
         end
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end else begin
         slot0_ff <= slot0_ff;
      end
   end

endmodule

### design/cfte_checker.sv
// port-level checks for the cube-face to panorama address block, bound to the top level
// depends on cfte_pkg
module cfte_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [cfte_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import cfte_pkg::*;

   // queue is empty right after reset
   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rst_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("not ready after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // pad bits above the two fields stay zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:COL_W+ROWO_W] == '0)
      else $error("result pad bits set");

endmodule

bind cubemap_face_to_equirect_address cfte_checker u_cfte_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
